// ===== rtl/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// shared types and constants of the keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned QTY_W = 32;
  localparam int unsigned TAG_W = 64;
  localparam int unsigned REC_W = QTY_W + TAG_W;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;   // clear valid flag of slot at scan address
    logic scan_rd;    // read slot at scan address for compare
    logic req_load;   // capture request fields, reset search results
    logic commit;     // write back the table change
    logic rsp_load;   // load result into output register
  } krt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic addr_last;  // scan address is on the last slot
    logic rsp_free;   // output register can take a result this cycle
  } krt_stat_t;

endpackage

// ===== rtl/krt_if.sv =====
// ----------------------------------------------------------------------------
// krt_req_if / krt_rsp_if
// request and result channels of the keyed record table
// ----------------------------------------------------------------------------
interface krt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] key_id;
  logic signed [31:0] quantity;
  logic [63:0]        name_tag;

  modport source (output valid, output req_type, output key_id, output quantity,
                  output name_tag, input ready);
  modport sink   (input valid, input req_type, input key_id, input quantity,
                  input name_tag, output ready);
endinterface

interface krt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] found_quantity;
  logic [63:0]        found_name_tag;

  modport source (output valid, output status, output found_quantity,
                  output found_name_tag, input ready);
  modport sink   (input valid, input status, input found_quantity,
                  input found_name_tag, output ready);
endinterface

// ===== rtl/krt_ctrl.sv =====
// ----------------------------------------------------------------------------
// krt_ctrl
// sequencer: clearing pass, slot scan, write-back and result hand-off
// ----------------------------------------------------------------------------
module krt_ctrl import krt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  krt_stat_t stat_i,
  output krt_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_LAST   = 6'b001000,
    S_COMMIT = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (stat_i.addr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.addr_last) state_d = S_LAST;
      end
      // compare of the last slot happens here
      S_LAST: state_d = S_COMMIT;
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (stat_i.rsp_free) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/krt_datapath.sv =====
// ----------------------------------------------------------------------------
// krt_datapath
// slot memories, scan address, key compare and result register
// ----------------------------------------------------------------------------
module krt_datapath import krt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  krt_req_if.sink    req_i,
  krt_rsp_if.source  rsp_o,
  input  krt_cmd_t   cmd_i,
  output krt_stat_t  stat_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  // slot memories: {valid, key} and {quantity, tag}
  logic [KEY_W:0]   key_mem  [TABLE_DEPTH];
  logic [REC_W-1:0] data_mem [TABLE_DEPTH];

  logic [IDX_W-1:0] addr_q, addr_d;
  logic [IDX_W-1:0] rd_idx_q;
  logic [KEY_W:0]   key_rd_q;
  logic [REC_W-1:0] data_rd_q;
  logic             rd_vld_q;

  req_e             req_type_q;
  logic [KEY_W-1:0] req_key_q;
  logic [REC_W-1:0] req_rec_q;

  logic             hit_q, free_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  logic [REC_W-1:0] found_rec_q;

  logic             rsp_valid_q;
  status_e          rsp_status_q;
  logic [REC_W-1:0] rsp_rec_q;

  logic             match, empty;
  logic             do_insert, do_update, do_delete;
  logic             key_we, data_we;
  logic [IDX_W-1:0] key_wa, data_wa;
  logic [KEY_W:0]   key_wd;
  status_e          status;

  // scan address, wraps to zero after the last slot
  assign stat_o.addr_last = (addr_q == IDX_W'(TABLE_DEPTH - 1));
  always_comb begin
    addr_d = addr_q;
    if (cmd_i.clear_wr || cmd_i.scan_rd) begin
      addr_d = stat_o.addr_last ? '0 : addr_q + IDX_W'(1);
    end
  end

  // compare stage, one slot per cycle
  assign match = rd_vld_q && key_rd_q[KEY_W] && (key_rd_q[KEY_W-1:0] == req_key_q);
  assign empty = rd_vld_q && !key_rd_q[KEY_W];

  assign do_insert = (req_type_q == REQ_INSERT) && !hit_q && free_q;
  assign do_update = (req_type_q == REQ_UPDATE) && hit_q;
  assign do_delete = (req_type_q == REQ_DELETE) && hit_q;

  always_comb begin
    case (req_type_q)
      REQ_INSERT: status = hit_q ? ST_DUP : (free_q ? ST_OK : ST_FULL);
      default:    status = hit_q ? ST_OK : ST_NOT_FOUND;
    endcase
  end

  // write-back
  assign key_we  = cmd_i.clear_wr || (cmd_i.commit && (do_insert || do_delete));
  assign key_wa  = cmd_i.clear_wr ? addr_q : (do_insert ? free_idx_q : hit_idx_q);
  assign key_wd  = cmd_i.clear_wr ? '0 : {do_insert, req_key_q};
  assign data_we = cmd_i.commit && (do_insert || do_update);
  assign data_wa = do_insert ? free_idx_q : hit_idx_q;

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_rd_q <= key_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (data_we) data_mem[data_wa] <= req_rec_q;
    data_rd_q <= data_mem[addr_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (cmd_i.req_load) begin
      req_type_q <= req_e'(req_i.req_type);
      req_key_q  <= req_i.key_id;
      req_rec_q  <= {req_i.quantity, req_i.name_tag};
    end
    if (cmd_i.req_load) begin
      found_rec_q <= '0;
    end else if (match) begin
      found_rec_q <= data_rd_q;
    end
    if (match) hit_idx_q <= rd_idx_q;
    if (empty && !free_q) free_idx_q <= rd_idx_q;
    if (cmd_i.rsp_load) begin
      rsp_status_q <= status;
      rsp_rec_q    <= found_rec_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.req_load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (match) hit_q <= 1'b1;
        if (empty) free_q <= 1'b1;
      end
      if (cmd_i.rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.rsp_free = !rsp_valid_q || rsp_o.ready;

  assign req_i.ready          = cmd_i.req_load;
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.found_quantity = rsp_rec_q[REC_W-1:TAG_W];
  assign rsp_o.found_name_tag = rsp_rec_q[TAG_W-1:0];

endmodule

// ===== rtl/keyed_record_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_top
// exact-match table of records keyed by a 32-bit id
// ----------------------------------------------------------------------------
// Each request inserts, looks up, updates or deletes one record by its key and
// returns exactly one result: a status and the record as stored before the
// request (zero when no slot matched). Slots live in two memories with one
// read and one write port each, {valid, key} and {quantity, name tag}, read
// one slot per cycle. From acceptance to the next accepted request, a request
// passes these steps in order: acceptance, the slot reads, the compare of the
// last slot, the write-back, and the hand-off of the result to the output
// register, where the result is valid once registered. The output register
// holds a result until it is taken; a blocked result stalls the sequencer
// before it accepts the next request. After reset a clearing pass clears
// every valid flag, and no request is accepted until it ends. Insert puts a
// new key in the lowest free slot.
// ----------------------------------------------------------------------------
module keyed_record_table_top import krt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH  // 2 to 4096 slots
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  krt_req_if.sink   req_i,
  krt_rsp_if.source rsp_o
);

  krt_cmd_t  cmd;
  krt_stat_t stat;
  logic      ctrl_ready;

  // sequencer: clear pass, scan, commit, result
  krt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ctrl_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // memories, compare and output register
  krt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

`ifndef ASSERT_OFF
  // a request handshake always starts a scan
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && ctrl_ready) |-> cmd.req_load)
    else $error("request accepted without starting a scan");

  // a result is only loaded when the output register can hold it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rsp_load |-> stat.rsp_free)
    else $error("result loaded over an untaken result");

  // write-back follows the end of the scan, after the last-slot compare state
  a_commit_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> $past(cmd.scan_rd, 2) && !$past(cmd.scan_rd))
    else $error("write-back out of sequence");
`endif

endmodule
